// ===== hw/rtl/icp_pkg.sv =====
// Package for the inversion count block: payload structs, widths, the prime
// modulus, the control state encoding and the modular add/subtract helpers.
// No dependencies; used by inversion_count_permutations and its testbench.
`default_nettype none

package icp_pkg;

  localparam int unsigned NW   = 7;   // perm_size width
  localparam int unsigned KW   = 11;  // inversions width
  localparam int unsigned CNTW = 30;  // count width

  localparam logic [CNTW-1:0] MODULUS = 30'd1000000007;

  typedef struct packed {
    logic [NW-1:0] perm_size;
    logic [KW-1:0] inversions;
  } in_t;

  typedef struct packed {
    logic [CNTW-1:0] count;
    logic            out_of_range;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_GAP  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  // (a + b) mod p for a, b already reduced.
  function automatic logic [CNTW-1:0] mod_add(input logic [CNTW-1:0] a,
                                              input logic [CNTW-1:0] b);
    logic [CNTW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODULUS}) begin
      s = s - {1'b0, MODULUS};
    end
    return s[CNTW-1:0];
  endfunction

  // (a - b) mod p for a, b already reduced.
  function automatic logic [CNTW-1:0] mod_sub(input logic [CNTW-1:0] a,
                                              input logic [CNTW-1:0] b);
    logic [CNTW:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
    end
    return s[CNTW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/inversion_count_permutations.sv =====
// A query walks rows 2..n of the table, where k' = min(k, n(n-1)/2 - k). Each row issues
// columns 0..k' in RUN with one table entry per cycle through the row RAMs, then passes GAP.
// Out-of-range k or n <= 1 skips the walk and goes straight to DONE. One query at a time; the
// next input is taken the cycle after the result is parked in the output register, and the
// result waits in DONE while the output stalls. Reset clears state, counters, window and valid
// flags; the result and write-stage registers and the row RAMs are not cleared.
`default_nettype none

module inversion_count_permutations
  import icp_pkg::*;
#(
  parameter int unsigned MAX_N = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_stall_o,
  input  wire in_t  in_data_i,
  output      logic out_valid_o,
  input  wire logic out_stall_i,
  output      out_t out_data_o
);

  // After folding by symmetry, k' never exceeds half the row length, and
  // never exceeds the largest encodable inversion count.
  localparam int unsigned RowMax   = MAX_N * (MAX_N - 1) / 2;
  localparam int unsigned KfHalf   = RowMax / 2;
  localparam int unsigned KInMax   = (1 << KW) - 1;
  localparam int unsigned KfMax    = (KfHalf > KInMax) ? KInMax : KfHalf;
  localparam int unsigned RamDepth = (KfMax + 1 < 2) ? 2 : KfMax + 1;
  localparam int unsigned AW       = $clog2(RamDepth);
  localparam int unsigned CW       = (AW > NW) ? AW : NW;
  localparam int unsigned TW       = 2 * NW;          // n*(n-1) width
  localparam logic [NW+1:0] MaxNW  = (NW+2)'(MAX_N);

  // ---------------------------------------------------------------------
  // Query setup: saturate n (zero counts as one), compute the largest k, test range, fold k.
  // ---------------------------------------------------------------------
  logic [NW-1:0] n_sat, n_eff;
  logic [TW-1:0] prod;
  logic [TW-2:0] total;
  logic          k_oor;
  logic [TW-2:0] k_wide, k_fold;

  always_comb begin
    n_sat  = ({2'b00, in_data_i.perm_size} > MaxNW) ? MaxNW[NW-1:0]
                                                    : in_data_i.perm_size;
    n_eff  = (n_sat == '0) ? NW'(1) : n_sat;
    prod   = TW'(n_eff) * TW'(n_eff - NW'(1));
    total  = prod[TW-1:1];
    k_wide = (TW-1)'(in_data_i.inversions);
    k_oor  = k_wide > total;
    k_fold = ({k_wide[TW-3:0], 1'b0} > total) ? (total - k_wide) : k_wide;
  end

  // ---------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------
  state_e        state_q, state_d;
  logic [NW-1:0] n_q, n_d;          // target row
  logic [NW-1:0] i_q, i_d;          // row being built
  logic [AW-1:0] kf_q, kf_d;        // last column of each row
  logic [AW-1:0] j_q, j_d;          // column whose reads are issued
  logic          sel_q, sel_d;      // RAM holding the previous row
  logic          first_q, first_d;  // previous row is the implicit row 1
  out_t          res_q, res_d;

  logic in_acc;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Column-level flags at read issue time.
  logic          j_ge_i, j_eq_i, j_last;
  logic [AW-1:0] j_back;

  assign j_ge_i = CW'(j_q) >= CW'(i_q);
  assign j_eq_i = CW'(j_q) == CW'(i_q);
  assign j_last = (j_q == kf_q);
  assign j_back = j_q - AW'(i_q);

  // ---------------------------------------------------------------------
  // Read-modify-write stage: RAM data returns in the cycle after the issue,
  // is folded into the window sum, and lands in the other RAM.
  // ---------------------------------------------------------------------
  logic          s_vld_q;
  logic          s_last_q, s_sub_q, s_first_q, s_ainit_q, s_binit_q, s_sel_q;
  logic [AW-1:0] s_addr_q;
  logic [CNTW-1:0] win_q, win_d;

  logic [CNTW-1:0] r0a, r0b, r1a, r1b;
  logic [CNTW-1:0] above, above_back, w_add, w_new;

  always_comb begin
    if (s_first_q) begin
      above      = CNTW'(s_ainit_q);
      above_back = CNTW'(s_binit_q);
    end else begin
      above      = s_sel_q ? r1a : r0a;
      above_back = s_sel_q ? r1b : r0b;
    end
    w_add = mod_add(win_q, above);
    w_new = s_sub_q ? mod_sub(w_add, above_back) : w_add;
  end

  // Row RAMs, used ping-pong: read RAM[sel], write RAM[!sel].
  logic we0, we1;
  assign we0 = s_vld_q &&  s_sel_q;
  assign we1 = s_vld_q && !s_sel_q;

  icp_ram #(.WIDTH(CNTW), .DEPTH(RamDepth)) u_row0 (
    .clk_i     (clk_i),
    .we_i      (we0),
    .waddr_i   (s_addr_q),
    .wdata_i   (w_new),
    .raddr_a_i (j_q),
    .rdata_a_o (r0a),
    .raddr_b_i (j_back),
    .rdata_b_o (r0b)
  );

  icp_ram #(.WIDTH(CNTW), .DEPTH(RamDepth)) u_row1 (
    .clk_i     (clk_i),
    .we_i      (we1),
    .waddr_i   (s_addr_q),
    .wdata_i   (w_new),
    .raddr_a_i (j_q),
    .rdata_a_o (r1a),
    .raddr_b_i (j_back),
    .rdata_b_o (r1b)
  );

  // ---------------------------------------------------------------------
  // Output register; a finished result waits here so the next query can
  // be accepted in the meantime.
  // ---------------------------------------------------------------------
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;
  logic out_load;

  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // Sequencer. RUN issues one column per cycle; GAP lets the last write of
  // a row settle before the next row reads it.
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    i_d     = i_q;
    kf_d    = kf_q;
    j_d     = j_q;
    sel_d   = sel_q;
    first_d = first_q;
    res_d   = res_q;
    win_d   = win_q;

    if (s_vld_q) begin
      win_d = s_last_q ? '0 : w_new;
      if (s_last_q) begin
        res_d.count        = w_new;
        res_d.out_of_range = 1'b0;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          n_d     = n_eff;
          i_d     = NW'(2);
          kf_d    = k_fold[AW-1:0];
          j_d     = '0;
          sel_d   = 1'b0;
          first_d = 1'b1;
          win_d   = '0;
          if (k_oor) begin
            res_d.count        = '0;
            res_d.out_of_range = 1'b1;
            state_d            = ST_DONE;
          end else if (n_eff == NW'(1)) begin
            res_d.count        = CNTW'(1);
            res_d.out_of_range = 1'b0;
            state_d            = ST_DONE;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        j_d = j_q + AW'(1);
        if (j_last) begin
          state_d = ST_GAP;
        end
      end
      ST_GAP: begin
        if (i_q == n_q) begin
          state_d = ST_DONE;
        end else begin
          i_d     = i_q + NW'(1);
          j_d     = '0;
          sel_d   = !sel_q;
          first_d = 1'b0;
          state_d = ST_RUN;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      s_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      i_q         <= '0;
      kf_q        <= '0;
      j_q         <= '0;
      sel_q       <= 1'b0;
      first_q     <= 1'b0;
      win_q       <= '0;
    end else begin
      state_q     <= state_d;
      s_vld_q     <= (state_q == ST_RUN);
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      i_q         <= i_d;
      kf_q        <= kf_d;
      j_q         <= j_d;
      sel_q       <= sel_d;
      first_q     <= first_d;
      win_q       <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_last_q  <= j_last;
    s_sub_q   <= j_ge_i;
    s_first_q <= first_q;
    s_ainit_q <= (j_q == '0);
    s_binit_q <= j_eq_i;
    s_sel_q   <= sel_q;
    s_addr_q  <= j_q;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_stage_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_vld_q |-> $past(state_q == ST_RUN))
    else $error("write stage active without a read issue");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (j_q <= kf_q))
    else $error("column counter ran past the folded k");

  a_gap_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GAP) |-> (s_vld_q && s_last_q))
    else $error("row gap without the last column in the write stage");

  a_win_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_q < MODULUS))
    else $error("window sum not reduced");

  a_out_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.count < MODULUS))
    else $error("result count not reduced");

endmodule

`default_nettype wire

// ===== hw/rtl/icp_ram.sv =====
// Generic synchronous RAM: one write port and two read ports, read data
// registered. Contents are undefined until written.
// No dependencies.
`default_nettype none

module icp_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_a_i,
  output      logic [WIDTH-1:0]                 rdata_a_o,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_b_i,
  output      logic [WIDTH-1:0]                 rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== sim/inversion_count_permutations_tb.sv =====
// Testbench for inversion_count_permutations: Mahonian counts of (n, k) modulo
// 1000000007 are checked against a self-contained row-by-row predictor.
// Depends on icp_pkg for the payload structs and the modulus.
`default_nettype none

module inversion_count_permutations_tb;
  import icp_pkg::*;

  localparam int unsigned MAX_ELEMS      = 64;
  localparam int unsigned ROW_LEN        = MAX_ELEMS * (MAX_ELEMS - 1) / 2 + 1;
  localparam int unsigned RANDOM_QUERIES = 100;
  // Only a handful of random queries may draw k from the full range at any size,
  // since a 64-element query near the middle of its row has the longest table walk.
  localparam int unsigned LARGE_BUDGET   = 4;
  localparam int unsigned LONG_HOLD      = 2000;

  // Scoreboard: predicts the answer of every accepted query and keeps the
  // predictions in order until the matching answer transaction arrives.
  class mahonian_book;
    out_t        pending[$];
    int unsigned errors;
    int unsigned results_seen;
    longint unsigned prev_row[ROW_LEN];
    longint unsigned next_row[ROW_LEN];

    // Builds the table one row at a time. Entry j of row r is the sum of
    // entries j-r+1..j of row r-1, kept as a sliding window.
    function out_t mahonian(in_t q);
      int unsigned     n;
      int unsigned     k;
      int unsigned     top;
      int unsigned     r;
      int unsigned     j;
      longint unsigned p;
      longint unsigned window;
      out_t            res;
      p   = longint'(MODULUS);
      res = '0;
      n   = q.perm_size;
      if (n > MAX_ELEMS) begin
        n = MAX_ELEMS;
      end
      if (n == 0) begin
        n = 1;
      end
      top = n * (n - 1) / 2;
      if (q.inversions > top) begin
        res.out_of_range = 1'b1;
        return res;
      end
      // Rows are symmetric, so only the lower half ever needs building.
      k = q.inversions;
      if (2 * k > top) begin
        k = top - k;
      end
      for (j = 0; j <= k; j++) begin
        prev_row[j] = (j == 0) ? 1 : 0;
      end
      for (r = 2; r <= n; r++) begin
        window = 0;
        for (j = 0; j <= k; j++) begin
          window = (window + prev_row[j]) % p;
          if (j >= r) begin
            window = (window + p - prev_row[j - r]) % p;
          end
          next_row[j] = window;
        end
        for (j = 0; j <= k; j++) begin
          prev_row[j] = next_row[j];
        end
      end
      res.count = prev_row[k][CNTW-1:0];
      return res;
    endfunction

    function void note_query(in_t q);
      pending.push_back(mahonian(q));
    endfunction

    function void check_answer(out_t got);
      out_t exp;
      results_seen++;
      if (pending.size() == 0) begin
        $error("answer with no query outstanding: count %0d, out_of_range %0d",
               got.count, got.out_of_range);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.count !== exp.count) begin
        $error("count: expected %0d, got %0d", exp.count, got.count);
        errors++;
      end
      if (got.out_of_range !== exp.out_of_range) begin
        $error("out_of_range: expected %0d, got %0d", exp.out_of_range,
               got.out_of_range);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic query_valid;
  logic query_stall;
  in_t  query;
  logic answer_valid;
  logic answer_stall;
  out_t answer;

  // Set for the last stretch of the run, where neither side idles.
  bit quiet;
  bit held_off;

  mahonian_book book;

  inversion_count_permutations #(
    .MAX_N(MAX_ELEMS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (query_valid),
    .in_stall_o (query_stall),
    .in_data_i  (query),
    .out_valid_o(answer_valid),
    .out_stall_i(answer_stall),
    .out_data_o (answer)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Offers one query transaction and returns at the falling edge after it
  // was accepted. Must be entered at a falling edge. A random idle burst may
  // come first; otherwise valid simply stays high into the next query.
  task automatic send_query(input in_t q);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      query_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    query_valid <= 1'b1;
    query       <= q;
    @(posedge clk);
    while (query_stall) begin
      @(posedge clk);
    end
    book.note_query(q);
    @(negedge clk);
  endtask

  task automatic send_pair(input int unsigned n, input int unsigned k);
    in_t q;
    q.perm_size  = NW'(n);
    q.inversions = KW'(k);
    send_query(q);
  endtask

  // Every answer transaction goes straight to the scoreboard. The stall is
  // only ever changed at the falling edge, so it is stable here.
  always @(posedge clk) begin
    if (rst_n && answer_valid && !answer_stall) begin
      book.check_answer(answer);
    end
  end

  // Receiver side: random stall bursts, plus one long hold-off during the
  // random phase. During the hold the block parks its answer, takes the next
  // query and then has to stall its input while the sender keeps offering.
  initial begin
    int unsigned burst;
    answer_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && book.results_seen == 30) begin
        held_off = 1'b1;
        answer_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        answer_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 5);
        answer_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        answer_stall <= 1'b0;
      end else begin
        answer_stall <= 1'b0;
      end
    end
  end

  // Main stimulus: reset, a directed set of corner queries, then random ones.
  initial begin
    in_t         q;
    int unsigned idx;
    int unsigned pick;
    int unsigned n_eff;
    int unsigned top;
    int unsigned large_left;
    book        = new();
    rst_n       = 1'b0;
    query_valid = 1'b0;
    query       = '0;
    quiet       = 1'b0;
    held_off    = 1'b0;
    large_left  = LARGE_BUDGET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero elements behave like one element.
    send_pair(0, 0);
    send_pair(0, 1);
    send_pair(1, 0);
    send_pair(2, 1);
    send_pair(3, 1);
    send_pair(4, 3);
    // Top of a row folds to zero; one past it is out of range.
    send_pair(5, 10);
    send_pair(5, 11);
    // Mirror pair: both must give the same count.
    send_pair(10, 20);
    send_pair(10, 25);
    // Middle of a larger row, where the count wraps the modulus.
    send_pair(20, 95);
    send_pair(20, 190);
    send_pair(64, 0);
    send_pair(64, 2016);
    send_pair(64, 2017);
    send_pair(64, 2047);
    // All-ones perm_size saturates to the largest size.
    send_pair(127, 2047);
    send_pair(65, 1);
    // The longest possible table walk, and folded ones near it.
    send_pair(64, 1008);
    send_pair(127, 1009);
    send_pair(64, 1024);

    // Random queries: mostly small sizes with k spread over the whole row and
    // just past it, some out-of-range queries over the full size range, and a
    // few queries drawn from the full range of both fields.
    for (idx = 0; idx < RANDOM_QUERIES; idx++) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        q.perm_size = NW'($urandom_range(0, 127));
      end else begin
        q.perm_size = NW'($urandom_range(0, 16));
      end
      n_eff = q.perm_size;
      if (n_eff > MAX_ELEMS) begin
        n_eff = MAX_ELEMS;
      end
      if (n_eff == 0) begin
        n_eff = 1;
      end
      top = n_eff * (n_eff - 1) / 2;
      if (pick < 4 && large_left > 0) begin
        q.inversions = KW'($urandom_range(0, 2047));
        large_left--;
      end else if (pick < 14) begin
        q.inversions = KW'($urandom_range(top + 1, 2047));
      end else begin
        q.inversions = KW'($urandom_range(0, top + 2));
      end
      quiet = (idx >= RANDOM_QUERIES - 15);
      send_query(q);
    end
    query_valid <= 1'b0;

    // Drain: wait for every predicted answer, then keep the clock running so a
    // stray extra answer would still be caught.
    while (book.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);
    if (book.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a run that never finishes.
  initial begin
    #48000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
